[rtl/i2cmbe_pkg.sv]
// Package for the I2C master bit engine: transfer payload types, command codes
// and the sequence lengths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2cmbe_pkg;

  // Bits in one data byte on the bus.
  localparam int unsigned BitsPerByte = 8;

  // Width of the tick counter within a command sequence.
  localparam int unsigned PhaseW = 6;

  // Command codes carried in the mode field.
  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_STOP  = 3'd1;
  localparam logic [2:0] MODE_WRITE = 3'd2;
  localparam logic [2:0] MODE_RACK  = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;
  localparam logic [2:0] MODE_SACK  = 3'd5;

  // Sequence lengths in ticks.
  localparam logic [PhaseW-1:0] LEN_SHORT = PhaseW'(4);
  localparam logic [PhaseW-1:0] LEN_WRITE = PhaseW'(2 + 4 * BitsPerByte);
  localparam logic [PhaseW-1:0] LEN_READ  = PhaseW'(1 + 2 * BitsPerByte);

  // Most significant bit of a byte; shifted right to select a bit.
  localparam logic [BitsPerByte-1:0] MSB_MASK = 8'h80;

  // One input tick.
  typedef struct packed {
    logic                   cmd_valid;
    logic [2:0]             mode;
    logic [BitsPerByte-1:0] byte_in;
    logic                   ack_level;
    logic                   sda_in;
  } in_item_t;

  // One result tick.
  typedef struct packed {
    logic                   scl_out;
    logic                   sda_out;
    logic                   busy_res;
    logic                   done_res;
    logic [BitsPerByte-1:0] read_data;
    logic                   ack_seen;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/i2c_master_bit_engine_top.sv]
// The result of an input transfer is in the output register in the cycle after it.
// Throughput: one tick per cycle; a new tick is taken while the output register
// is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous): engine idle, SCL and SDA released, bytes and
// acknowledge cleared, output register empty.
// Depends on i2cmbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_engine_top
  import i2cmbe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  // Engine state.
  logic [PhaseW-1:0]      phase_r, phase_nxt;
  logic [2:0]             mode_r, mode_nxt;
  logic                   busy_r, busy_nxt;
  logic [BitsPerByte-1:0] shift_out_r, shift_out_nxt;
  logic [BitsPerByte-1:0] shift_in_r, shift_in_nxt;
  logic                   ack_hold_r, ack_hold_nxt;
  logic                   scl_r, scl_nxt;
  logic                   sda_r, sda_nxt;
  logic                   send_r, send_nxt;

  // Output register.
  logic                   out_valid_r;
  out_item_t              out_data_r, out_data_nxt;

  logic                   take;
  logic                   cmd_take;
  logic [PhaseW-1:0]      phase_cur;
  logic [PhaseW-1:0]      phase_inc;
  logic [PhaseW-1:0]      seq_len;
  logic [PhaseW-1:0]      q_write;
  logic [PhaseW-1:0]      q_read;
  logic [2:0]             bit_write;
  logic [2:0]             bit_read;
  logic [BitsPerByte-1:0] mask_write;
  logic [BitsPerByte-1:0] mask_read;
  logic                   done;

  // A tick is taken whenever the output register can hold its result.
  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  // A command starts only from idle and only with a defined code.
  assign cmd_take = !busy_r && in_data.cmd_valid && (in_data.mode <= MODE_SACK);
  assign phase_cur = cmd_take ? '0 : phase_r;
  assign phase_inc = phase_cur + PhaseW'(1);

  // Bit positions inside the byte loops.
  assign q_write    = phase_cur - PhaseW'(2);
  assign q_read     = phase_cur - PhaseW'(1);
  assign bit_write  = q_write[4:2];
  assign bit_read   = q_read[3:1];
  assign mask_write = MSB_MASK >> bit_write;
  assign mask_read  = MSB_MASK >> bit_read;

  // Sequence length of the command in progress.
  always_comb begin
    unique case (mode_nxt)
      MODE_WRITE: seq_len = LEN_WRITE;
      MODE_READ:  seq_len = LEN_READ;
      default:    seq_len = LEN_SHORT;
    endcase
  end

  // One tick of the engine.
  always_comb begin
    mode_nxt      = cmd_take ? in_data.mode : mode_r;
    shift_out_nxt = (cmd_take && in_data.mode == MODE_WRITE) ? in_data.byte_in : shift_out_r;
    send_nxt      = (cmd_take && in_data.mode == MODE_SACK) ? in_data.ack_level : send_r;
    busy_nxt      = busy_r || cmd_take;
    phase_nxt     = phase_r;
    shift_in_nxt  = shift_in_r;
    ack_hold_nxt  = ack_hold_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    done          = 1'b0;

    if (busy_nxt) begin
      unique case (mode_nxt)
        MODE_START: begin
          unique case (phase_cur[1:0])
            2'd0:    sda_nxt = 1'b1;
            2'd1:    scl_nxt = 1'b1;
            2'd2:    sda_nxt = 1'b0;
            default: scl_nxt = 1'b0;
          endcase
        end
        MODE_STOP: begin
          unique case (phase_cur[1:0])
            2'd0:    sda_nxt = 1'b0;
            2'd1:    scl_nxt = 1'b0;
            2'd2:    scl_nxt = 1'b1;
            default: sda_nxt = 1'b1;
          endcase
        end
        MODE_SACK: begin
          unique case (phase_cur[1:0])
            2'd0:    scl_nxt = 1'b0;
            2'd1:    sda_nxt = send_nxt;
            2'd2:    scl_nxt = 1'b1;
            default: scl_nxt = 1'b0;
          endcase
        end
        MODE_RACK: begin
          unique case (phase_cur[1:0])
            2'd0:    scl_nxt = 1'b0;
            2'd1:    sda_nxt = 1'b1;
            2'd2: begin
              scl_nxt      = 1'b1;
              ack_hold_nxt = in_data.sda_in;
            end
            default: scl_nxt = 1'b0;
          endcase
        end
        MODE_WRITE: begin
          if (phase_cur == PhaseW'(0)) begin
            scl_nxt = 1'b0;
          end else if (phase_cur == PhaseW'(1)) begin
            sda_nxt = 1'b0;
          end else begin
            unique case (q_write[1:0])
              2'd0:    sda_nxt = |(shift_out_nxt & mask_write);
              2'd1:    scl_nxt = 1'b1;
              2'd2:    scl_nxt = 1'b0;
              default: sda_nxt = 1'b0;
            endcase
          end
        end
        default: begin
          // Read byte: release SDA, then sample one bit per SCL high phase.
          if (phase_cur == PhaseW'(0)) begin
            sda_nxt      = 1'b1;
            shift_in_nxt = '0;
          end else if (!q_read[0]) begin
            scl_nxt = 1'b1;
            if (in_data.sda_in) begin
              shift_in_nxt = shift_in_r | mask_read;
            end
          end else begin
            scl_nxt = 1'b0;
          end
        end
      endcase

      // Advance the tick counter and finish the sequence at its length.
      if (phase_inc >= seq_len) begin
        done      = 1'b1;
        busy_nxt  = 1'b0;
        phase_nxt = '0;
      end else begin
        phase_nxt = phase_inc;
      end
    end

    out_data_nxt.scl_out   = scl_nxt;
    out_data_nxt.sda_out   = sda_nxt;
    out_data_nxt.busy_res  = busy_r || cmd_take;
    out_data_nxt.done_res  = done;
    out_data_nxt.read_data = shift_in_nxt;
    out_data_nxt.ack_seen  = ack_hold_nxt;
  end

  // Engine state updates once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      mode_r      <= MODE_START;
      busy_r      <= 1'b0;
      shift_out_r <= '0;
      shift_in_r  <= '0;
      ack_hold_r  <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      send_r      <= 1'b0;
    end else if (take) begin
      phase_r     <= phase_nxt;
      mode_r      <= mode_nxt;
      busy_r      <= busy_nxt;
      shift_out_r <= shift_out_nxt;
      shift_in_r  <= shift_in_nxt;
      ack_hold_r  <= ack_hold_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      send_r      <= send_nxt;
    end
  end

  // Output register: loads on every accepted tick, empties on a result transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the I2C master bit engine top level.
// A scoreboard predicts every bus tick; tasks send ticks, an always block takes results.
// Depends on i2cmbe_pkg and i2c_master_bit_engine_top.
`timescale 1ns / 1ps

module testbench
  import i2cmbe_pkg::*;
();

  // How the SDA input is filled while a command sequence runs.
  localparam logic [1:0] SDA_LOW  = 2'd0;
  localparam logic [1:0] SDA_HIGH = 2'd1;
  localparam logic [1:0] SDA_RAND = 2'd2;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_TICKS   = 1800;

  // Tracks the engine state per accepted tick and holds the expected results.
  class bus_tick_board;
    logic [5:0] phase_cnt;
    logic [2:0] run_mode;
    logic       running;
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
    logic       ack_bit;
    logic       scl_lvl;
    logic       sda_lvl;
    logic       sack_lvl;
    out_item_t  expected_ticks[$];
    int         errors;
    int         ticks_taken;

    function new();
      phase_cnt   = '0;
      run_mode    = MODE_START;
      running     = 1'b0;
      tx_byte     = '0;
      rx_byte     = '0;
      ack_bit     = 1'b0;
      scl_lvl     = 1'b1;
      sda_lvl     = 1'b1;
      sack_lvl    = 1'b0;
      errors      = 0;
      ticks_taken = 0;
    endfunction

    function logic [5:0] seq_ticks(logic [2:0] m);
      case (m)
        MODE_WRITE: return 6'd34;
        MODE_READ:  return 6'd17;
        default:    return 6'd4;
      endcase
    endfunction

    // One pin write of the running sequence.
    function void advance_phase(logic sda);
      logic [5:0] q;
      logic [2:0] idx;
      case (run_mode)
        MODE_START: begin
          if (phase_cnt == 6'd0) sda_lvl = 1'b1;
          else if (phase_cnt == 6'd1) scl_lvl = 1'b1;
          else if (phase_cnt == 6'd2) sda_lvl = 1'b0;
          else scl_lvl = 1'b0;
        end
        MODE_STOP: begin
          if (phase_cnt == 6'd0) sda_lvl = 1'b0;
          else if (phase_cnt == 6'd1) scl_lvl = 1'b0;
          else if (phase_cnt == 6'd2) scl_lvl = 1'b1;
          else sda_lvl = 1'b1;
        end
        MODE_SACK: begin
          if (phase_cnt == 6'd0) scl_lvl = 1'b0;
          else if (phase_cnt == 6'd1) sda_lvl = sack_lvl;
          else if (phase_cnt == 6'd2) scl_lvl = 1'b1;
          else scl_lvl = 1'b0;
        end
        MODE_RACK: begin
          if (phase_cnt == 6'd0) scl_lvl = 1'b0;
          else if (phase_cnt == 6'd1) sda_lvl = 1'b1;
          else if (phase_cnt == 6'd2) begin
            scl_lvl = 1'b1;
            ack_bit = sda;
          end else scl_lvl = 1'b0;
        end
        MODE_WRITE: begin
          if (phase_cnt == 6'd0) scl_lvl = 1'b0;
          else if (phase_cnt == 6'd1) sda_lvl = 1'b0;
          else begin
            // Four ticks per bit, MSB first, zero bits included.
            q   = phase_cnt - 6'd2;
            idx = q[4:2];
            case (q[1:0])
              2'd0:    sda_lvl = tx_byte[3'd7 - idx];
              2'd1:    scl_lvl = 1'b1;
              2'd2:    scl_lvl = 1'b0;
              default: sda_lvl = 1'b0;
            endcase
          end
        end
        default: begin
          // Read byte: release SDA, then sample on each high SCL tick.
          if (phase_cnt == 6'd0) begin
            sda_lvl = 1'b1;
            rx_byte = '0;
          end else begin
            q   = phase_cnt - 6'd1;
            idx = q[3:1];
            if (!q[0]) begin
              scl_lvl = 1'b1;
              if (sda) rx_byte[3'd7 - idx] = 1'b1;
            end else begin
              scl_lvl = 1'b0;
            end
          end
        end
      endcase
    endfunction

    // Called for every accepted input transfer.
    function void note_tick(in_item_t t);
      out_item_t e;
      e = '0;
      ticks_taken++;
      if (!running && t.cmd_valid && t.mode <= MODE_SACK) begin
        running   = 1'b1;
        run_mode  = t.mode;
        phase_cnt = '0;
        if (t.mode == MODE_WRITE) tx_byte = t.byte_in;
        if (t.mode == MODE_SACK) sack_lvl = t.ack_level;
      end
      if (running) begin
        e.busy_res = 1'b1;
        advance_phase(t.sda_in);
        phase_cnt = phase_cnt + 6'd1;
        if (phase_cnt >= seq_ticks(run_mode)) begin
          e.done_res = 1'b1;
          running    = 1'b0;
          phase_cnt  = '0;
        end
      end
      e.scl_out   = scl_lvl;
      e.sda_out   = sda_lvl;
      e.read_data = rx_byte;
      e.ack_seen  = ack_bit;
      expected_ticks.push_back(e);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    // Called for every accepted result transfer.
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_ticks.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected none actual %h", $time, got);
        return;
      end
      want = expected_ticks.pop_front();
      compare_field("scl_out", want.scl_out, got.scl_out);
      compare_field("sda_out", want.sda_out, got.sda_out);
      compare_field("busy_res", want.busy_res, got.busy_res);
      compare_field("done_res", want.done_res, got.done_res);
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("ack_seen", want.ack_seen, got.ack_seen);
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int quiet_cycles    = 0;

  bus_tick_board board = new();

  i2c_master_bit_engine_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // Result side: check each transfer and stall at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) board.check_result(out_data);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** i2c_master_bit_engine_top: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic pick_sda(logic [1:0] sel);
    case (sel)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return 1'($urandom_range(1));
    endcase
  endfunction

  // A tick with random content; commands appear at the given rate in percent.
  function automatic in_item_t random_tick(int cmd_pct, logic [1:0] sda_sel);
    in_item_t t;
    t.cmd_valid = ($urandom_range(99) < cmd_pct);
    t.mode      = 3'($urandom_range(7));
    t.byte_in   = 8'($urandom_range(255));
    t.ack_level = 1'($urandom_range(1));
    t.sda_in    = pick_sda(sda_sel);
    return t;
  endfunction

  // Offers one tick and returns at the edge where it is accepted.
  task automatic send_tick(input in_item_t t);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_tick(t);
  endtask

  // Issues a command and keeps ticking until the sequence has finished.
  // Filler ticks carry ignored commands now and then.
  task automatic run_command(input logic [2:0] m, input logic [7:0] b, input logic a,
                             input logic [1:0] sda_sel);
    in_item_t t;
    t.cmd_valid = 1'b1;
    t.mode      = m;
    t.byte_in   = b;
    t.ack_level = a;
    t.sda_in    = pick_sda(sda_sel);
    send_tick(t);
    while (board.running) send_tick(random_tick(25, sda_sel));
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_ticks.size() != 0) @(posedge clk);
  endtask

  // A well-formed bus transaction: address, then reads or writes, then usually a stop.
  task automatic bus_transaction();
    logic [7:0] addr;
    int         n;
    addr = 8'($urandom_range(255));
    n    = $urandom_range(1, 3);
    run_command(MODE_START, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_RAND);
    run_command(MODE_WRITE, addr, 1'($urandom_range(1)), SDA_RAND);
    run_command(MODE_RACK, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_RAND);
    for (int i = 0; i < n; i++) begin
      if (addr[0]) begin
        run_command(MODE_READ, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_RAND);
        run_command(MODE_SACK, 8'($urandom_range(255)), (i == n - 1), SDA_RAND);
      end else begin
        run_command(MODE_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_RAND);
        run_command(MODE_RACK, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_RAND);
      end
    end
    // Now and then the stop is left out, so that the next start may come as a repeated start.
    if ($urandom_range(99) < 80)
      run_command(MODE_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_RAND);
  endtask

  // Random ticks of any content, then let a started sequence finish.
  task automatic bus_noise();
    repeat ($urandom_range(1, 8)) send_tick(random_tick(50, SDA_RAND));
    while (board.running) send_tick(random_tick(25, SDA_RAND));
  endtask

  task automatic set_idling(input int sel);
    case (sel)
      1: begin sender_idle_pct = 83; recv_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  recv_stall_pct = 83; end
      3: begin sender_idle_pct = 7;  recv_stall_pct = 7;  end
      default: begin sender_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  initial begin
    in_item_t t;
    int       txn;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle ticks with all fields low and all fields high but no command.
    t = '0;
    send_tick(t);
    t = '1;
    t.cmd_valid = 1'b0;
    send_tick(t);
    // Undefined modes are not taken.
    t = '0;
    t.cmd_valid = 1'b1;
    t.mode = 3'd6;
    send_tick(t);
    t.mode = 3'd7;
    t.byte_in = 8'hFF;
    t.ack_level = 1'b1;
    t.sda_in = 1'b1;
    send_tick(t);

    // Every command, byte extremes and both acknowledge levels.
    run_command(MODE_START, 8'h00, 1'b0, SDA_RAND);
    run_command(MODE_WRITE, 8'hFF, 1'b0, SDA_RAND);
    run_command(MODE_RACK, 8'h00, 1'b0, SDA_LOW);
    run_command(MODE_WRITE, 8'h00, 1'b1, SDA_RAND);
    run_command(MODE_RACK, 8'hFF, 1'b1, SDA_HIGH);
    run_command(MODE_WRITE, 8'hA5, 1'b0, SDA_RAND);
    run_command(MODE_READ, 8'h00, 1'b0, SDA_HIGH);
    run_command(MODE_SACK, 8'h00, 1'b0, SDA_RAND);
    run_command(MODE_READ, 8'hFF, 1'b1, SDA_LOW);
    run_command(MODE_SACK, 8'hFF, 1'b1, SDA_RAND);
    run_command(MODE_READ, 8'h5A, 1'b0, SDA_RAND);
    run_command(MODE_SACK, 8'h00, 1'b1, SDA_RAND);
    run_command(MODE_STOP, 8'h00, 1'b0, SDA_RAND);
    drain_results();

    // Random part: mostly well-formed transactions, some noise.
    txn = 0;
    while (board.ticks_taken < RANDOM_TICKS) begin
      set_idling(txn % 5);
      if ($urandom_range(99) < 85) bus_transaction();
      else bus_noise();
      if (txn % 7 == 3) drain_results();
      txn++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (board.errors == 0 && board.expected_ticks.size() == 0)
      $display("** i2c_master_bit_engine_top: PASSED **");
    else
      $display("** i2c_master_bit_engine_top: FAILED **");
    $finish;
  end

endmodule
